[hw/rtl/ntc_lut_pkg.sv]
`timescale 1ns / 1ps

package ntc_lut_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W       = (CNT_W > 9) ? CNT_W : 9;

  // Field widths.
  localparam int VOLT_W  = 16;
  localparam int RES_W   = 24;
  localparam int DIV_W   = 25;
  localparam int TOT_W   = 26;
  localparam int DROP_W  = 42;
  localparam int TEMP_W  = 10;
  localparam int BASE_W  = 9;
  localparam int CFG_W   = 24;
  localparam int CFGI_W  = 3;

  // Register indexes of the configuration port.
  typedef enum logic [CFGI_W-1:0] {
    CFG_REF_VOLTAGE      = 3'd0,
    CFG_RES_UPPER        = 3'd1,
    CFG_RES_UPPER_INNER  = 3'd2,
    CFG_RES_LOWER_INNER  = 3'd3,
    CFG_RES_LOWER        = 3'd4,
    CFG_TAP_MODE         = 3'd5,
    CFG_ENTRY_COUNT      = 3'd6,
    CFG_BASE_TEMPERATURE = 3'd7
  } cfg_idx_t;

  // Tap positions.
  typedef enum logic [1:0] {
    TAP_UP   = 2'd0,
    TAP_HIGH = 2'd1,
    TAP_LOW  = 2'd2,
    TAP_DOWN = 2'd3
  } tap_t;

  // Input operations.
  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_CONVERT = 1'b1
  } op_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV1,
    ST_WAIT1,
    ST_MUL,
    ST_SUB,
    ST_DIV2,
    ST_WAIT2,
    ST_WSTART,
    ST_WALK,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ram_we;
    logic load;
    logic div1_start;
    logic cap_current;
    logic mul;
    logic sub;
    logic div2_start;
    logic cap_res;
    logic walk_start;
    logic walk;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic walk_adv;
    logic out_valid;
  } dp_status_t;

endpackage

[hw/rtl/ntc_lut_ram.sv]
`timescale 1ns / 1ps

module ntc_lut_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/ntc_lut_div.sv]
`timescale 1ns / 1ps

module ntc_lut_div
  import ntc_lut_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [VOLT_W-1:0] dividend,
  input  logic [DIV_W-1:0]  divisor,
  output logic              done,
  output logic [VOLT_W-1:0] quotient
);

  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dvs;
  logic [VOLT_W-1:0] quo;
  logic [4:0]        count;
  logic              busy;
  logic [DIV_W:0]    shifted;
  logic              fits;

  // One quotient bit per cycle, restoring.
  assign shifted  = {rem, quo[VOLT_W-1]};
  assign fits     = shifted >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 5'(VOLT_W);
      end else if (busy) begin
        count <= count - 5'd1;
        if (count == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? DIV_W'(shifted - {1'b0, dvs}) : shifted[DIV_W-1:0];
      quo <= {quo[VOLT_W-2:0], fits};
    end
  end

endmodule

[hw/rtl/ntc_lut_ctrl.sv]
`timescale 1ns / 1ps

module ntc_lut_ctrl
  import ntc_lut_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_op,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (op_t'(in_op) == OP_WRITE) begin
            cmd.ram_we = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = ST_DIV1;
          end
        end
      end
      ST_DIV1: begin
        cmd.div1_start = 1'b1;
        state_next     = ST_WAIT1;
      end
      ST_WAIT1: begin
        if (status.div_done) begin
          cmd.cap_current = 1'b1;
          state_next      = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_SUB;
      end
      ST_SUB: begin
        cmd.sub    = 1'b1;
        state_next = ST_DIV2;
      end
      ST_DIV2: begin
        cmd.div2_start = 1'b1;
        state_next     = ST_WAIT2;
      end
      ST_WAIT2: begin
        if (status.div_done) begin
          cmd.cap_res = 1'b1;
          state_next  = ST_WSTART;
        end
      end
      ST_WSTART: begin
        cmd.walk_start = 1'b1;
        state_next     = ST_WALK;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (!status.walk_adv) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status.out_valid) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/ntc_lut_dp.sv]
`timescale 1ns / 1ps

module ntc_lut_dp
  import ntc_lut_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic [7:0]        entry_index,
  input  logic [15:0]       entry_resistance,
  input  logic [VOLT_W-1:0] adc_sample,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [15:0]       resistance,
  output logic [TEMP_W-1:0] temperature,
  output logic              out_status
);

  // Configuration registers.
  logic [VOLT_W-1:0] ref_voltage;
  logic [RES_W-1:0]  res_upper;
  logic [RES_W-1:0]  res_upper_inner;
  logic [RES_W-1:0]  res_lower_inner;
  logic [RES_W-1:0]  res_lower;
  logic [1:0]        tap_mode;
  logic [8:0]        entry_count;
  logic [BASE_W-1:0] base_temperature;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_voltage      <= 16'd3300;
      res_upper        <= 24'd10000;
      res_upper_inner  <= '0;
      res_lower_inner  <= '0;
      res_lower        <= '0;
      tap_mode         <= TAP_UP;
      entry_count      <= 9'd1;
      base_temperature <= 9'h1D8;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_REF_VOLTAGE:      ref_voltage      <= cfg_data[VOLT_W-1:0];
        CFG_RES_UPPER:        res_upper        <= cfg_data;
        CFG_RES_UPPER_INNER:  res_upper_inner  <= cfg_data;
        CFG_RES_LOWER_INNER:  res_lower_inner  <= cfg_data;
        CFG_RES_LOWER:        res_lower        <= cfg_data;
        CFG_TAP_MODE:         tap_mode         <= cfg_data[1:0];
        CFG_ENTRY_COUNT:      entry_count      <= cfg_data[8:0];
        CFG_BASE_TEMPERATURE: base_temperature <= cfg_data[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the sample and pick numerator and divisor for the tap.
  logic [VOLT_W-1:0] sample_c;
  logic [VOLT_W-1:0] num_c;
  logic [DIV_W-1:0]  div_c;

  always_comb begin
    sample_c = (adc_sample > ref_voltage) ? ref_voltage : adc_sample;
    case (tap_t'(tap_mode))
      TAP_UP: begin
        num_c = ref_voltage - sample_c;
        div_c = DIV_W'(res_upper);
      end
      TAP_HIGH: begin
        num_c = ref_voltage - sample_c;
        div_c = DIV_W'(res_upper) + DIV_W'(res_upper_inner);
      end
      TAP_LOW: begin
        num_c = sample_c;
        div_c = DIV_W'(res_lower_inner) + DIV_W'(res_lower);
      end
      default: begin
        num_c = sample_c;
        div_c = DIV_W'(res_lower);
      end
    endcase
  end

  logic [VOLT_W-1:0] num;
  logic [DIV_W-1:0]  divisor;
  logic              div_zero;
  logic [TOT_W-1:0]  total;
  logic [VOLT_W-1:0] current;
  logic [DROP_W-1:0] drop;
  logic [VOLT_W-1:0] volt;
  logic [15:0]       res;
  logic [IDX_W-1:0]  idx;

  // Shared serial divider.
  logic              div_start;
  logic [VOLT_W-1:0] div_dividend;
  logic [DIV_W-1:0]  div_divisor;
  logic              div_done;
  logic [VOLT_W-1:0] quotient;

  assign div_start    = cmd.div1_start | cmd.div2_start;
  assign div_dividend = cmd.div2_start ? volt : num;
  assign div_divisor  = cmd.div2_start ?
                        ((current == '0) ? DIV_W'(1) : DIV_W'(current)) : divisor;

  ntc_lut_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Arithmetic registers, one step per command.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num      <= num_c;
      divisor  <= div_c;
      div_zero <= (div_c == '0);
      total    <= TOT_W'(res_upper) + TOT_W'(res_upper_inner)
                + TOT_W'(res_lower_inner) + TOT_W'(res_lower);
    end
    if (cmd.cap_current) begin
      current <= div_zero ? '0 : quotient;
    end
    if (cmd.mul) begin
      drop <= DROP_W'(current) * DROP_W'(total);
    end
    if (cmd.sub) begin
      volt <= (DROP_W'(ref_voltage) > drop) ? ref_voltage - drop[VOLT_W-1:0] : '0;
    end
    if (cmd.cap_res) begin
      res <= quotient;
    end
  end

  // Effective entry count: zero reads as one, large values saturate.
  logic [CMP_W-1:0] count_eff;
  logic [CMP_W-1:0] idx_plus;
  logic [15:0]      rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic             walk_adv;
  logic             wr_en;

  always_comb begin
    if (entry_count == '0) begin
      count_eff = CMP_W'(1);
    end else if (CMP_W'(entry_count) > CMP_W'(TABLE_DEPTH)) begin
      count_eff = CMP_W'(TABLE_DEPTH);
    end else begin
      count_eff = CMP_W'(entry_count);
    end
  end

  // Read data always holds the entry after idx during the walk.
  assign idx_plus = CMP_W'(idx) + CMP_W'(1);
  assign walk_adv = cmd.walk && (idx_plus < count_eff) && (rd_data >= res);
  assign rd_addr  = cmd.walk_start ? IDX_W'(1) :
                    walk_adv ? IDX_W'(idx + IDX_W'(2)) : IDX_W'(idx + IDX_W'(1));
  assign wr_en    = cmd.ram_we && (32'(entry_index) < TABLE_DEPTH);

  ntc_lut_ram #(
    .WIDTH (16),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (IDX_W'(entry_index)),
    .wdata (entry_resistance),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Walk index.
  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      idx <= '0;
    end else if (walk_adv) begin
      idx <= idx + IDX_W'(1);
    end
  end

  // Output register: holds one result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      resistance  <= res;
      temperature <= TEMP_W'(idx) + {base_temperature[BASE_W-1], base_temperature};
      out_status  <= div_zero;
    end
  end

  assign status.div_done  = div_done;
  assign status.walk_adv  = walk_adv;
  assign status.out_valid = out_valid && !out_ready;

endmodule

[hw/rtl/ntc_table_temperature_lookup_unit.sv]
`timescale 1ns / 1ps

// NTC divider reading to resistance and temperature, by table lookup.
// Input channel s_axis: tuser selects a table write or a conversion. A write
// stores entry_resistance at entry_index and gives no result. A conversion
// clamps the sample to the reference, divides by the tap's resistor sum,
// subtracts the drop over all four resistors, divides by the current and
// walks the resistance table.
// Output channel m_axis: one result per conversion, resistance and
// temperature in tdata, the zero-divisor flag in tuser.
// A conversion result is presented after the table walk has stepped over n
// entries, n at most the entry count less one; the next item can be accepted
// as soon as the result is presented. Both divisions run in the shared
// 16-step serial divider, and the table walk reads one entry per cycle.
// One conversion is in work at a time; a new item is taken once the result
// has moved to the output register. A stalled receiver holds the result in
// the output register; a finished second conversion then waits until the
// first is taken. Reset clears the control state and loads the register
// defaults; table contents are undefined until written. Configuration is
// to be written while idle; the block itself does not enforce this.

module ntc_table_temperature_lookup_unit
  import ntc_lut_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // entry_index[7:0], entry_resistance[23:8], adc_sample[39:24]
  input  logic [39:0]       s_axis_tdata,
  // operation[0]
  input  logic [0:0]        s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // resistance[15:0], temperature[25:16], zero fill[31:26]
  output logic [31:0]       m_axis_tdata,
  // status[0]
  output logic [0:0]        m_axis_tuser
);

  dp_cmd_t     cmd;
  dp_status_t  status;
  logic [15:0] resistance;
  logic [TEMP_W-1:0] temperature;
  logic        out_status;

  ntc_lut_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser[0]),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ntc_lut_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .entry_index      (s_axis_tdata[7:0]),
    .entry_resistance (s_axis_tdata[23:8]),
    .adc_sample       (s_axis_tdata[39:24]),
    .cmd              (cmd),
    .status           (status),
    .out_ready        (m_axis_tready),
    .out_valid        (m_axis_tvalid),
    .resistance       (resistance),
    .temperature      (temperature),
    .out_status       (out_status)
  );

  assign m_axis_tdata = {6'd0, temperature, resistance};
  assign m_axis_tuser = out_status;

`ifndef SYNTH
  // A result is only loaded when the output register is free or being taken.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded over a waiting result");

  // The divider never reports done in the cycle after a start.
  a_div_time: assert property (@(posedge clk) disable iff (rst)
    (cmd.div1_start || cmd.div2_start) |=> !status.div_done)
    else $error("divider finished too early");

  // Accept, table write and result load are exclusive.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.ram_we, cmd.out_load}))
    else $error("conflicting datapath commands");
`endif

endmodule
